// ----- sv/clfp_pkg.sv -----
// Shared types, constants and word tables of the command line framer and parser.
`timescale 1ns / 1ps
package clfp_pkg;

  localparam int unsigned LineCapacityDef = 64;
  localparam int unsigned EvDepthDef      = 4;
  localparam int unsigned MaxTokens       = 8;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_VALID  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [4:0] OP_HELLO    = 5'd0;
  localparam logic [4:0] OP_PROBE    = 5'd6;
  localparam logic [4:0] OP_LED      = 5'd7;
  localparam logic [4:0] OP_GPIO     = 5'd8;
  localparam logic [4:0] OP_SD_MOUNT = 5'd9;
  localparam logic [4:0] OP_BLE_PROF = 5'd13;
  localparam logic [4:0] OP_RADIO_ID = 5'd17;
  localparam logic [4:0] OP_RADIO_PG = 5'd18;
  localparam logic [4:0] OP_UTC      = 5'd19;
  localparam logic [4:0] OP_I2C      = 5'd20;

  // Second-token words.
  localparam int unsigned N1 = 14;
  localparam int unsigned W1_PROBE = 6;
  localparam int unsigned W1_LED   = 7;
  localparam int unsigned W1_GPIO  = 8;
  localparam int unsigned W1_SD    = 9;
  localparam int unsigned W1_BLE   = 10;
  localparam int unsigned W1_RADIO = 11;
  localparam int unsigned W1_UTC   = 12;
  localparam int unsigned W1_I2C   = 13;
  // Third-token words: eight devices, then the nouns.
  localparam int unsigned N2 = 17;
  localparam int unsigned W2_MOUNT   = 8;
  localparam int unsigned W2_PROFILE = 12;
  localparam int unsigned W2_PING    = 15;
  localparam int unsigned W2_ID      = 16;

  localparam logic [11:0] UTC_LOW  [6] = '{12'd2000, 12'd1, 12'd1, 12'd0, 12'd0, 12'd0};
  localparam logic [11:0] UTC_HIGH [6] = '{12'd2099, 12'd12, 12'd31, 12'd23, 12'd59, 12'd59};
  localparam logic [11:0] I2C_LOW  = 12'd8;
  localparam logic [11:0] I2C_HIGH = 12'd119;
  localparam logic [11:0] REG_HIGH = 12'd255;
  localparam logic [11:0] GPIO_HIGH = 12'd7;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       discard_after_reset;
  } clfp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  operation;
    logic [31:0] command_id;
    logic [11:0] arg_first;
    logic [7:0]  arg_second;
    logic [4:0]  arg_third;
    logic [4:0]  arg_fourth;
    logic [5:0]  arg_fifth;
    logic [5:0]  arg_sixth;
  } clfp_out_t;

  typedef enum logic [1:0] {
    EV_BYTE    = 2'd0,
    EV_CLEAR   = 2'd1,
    EV_END     = 2'd2,
    EV_END_REJ = 2'd3
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
  } ev_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] text;
  } word_t;

  function automatic word_t tok1_word(logic [3:0] i);
    word_t w;
    w = '0;
    case (i)
      4'd0:    w = '{4'd5, {"hello", 24'h0}};
      4'd1:    w = '{4'd6, {"status", 16'h0}};
      4'd2:    w = '{4'd4, {"beep", 32'h0}};
      4'd3:    w = '{4'd4, {"stop", 32'h0}};
      4'd4:    w = '{4'd4, {"uart", 32'h0}};
      4'd5:    w = '{4'd3, {"spi", 40'h0}};
      4'd6:    w = '{4'd5, {"probe", 24'h0}};
      4'd7:    w = '{4'd3, {"led", 40'h0}};
      4'd8:    w = '{4'd4, {"gpio", 32'h0}};
      4'd9:    w = '{4'd2, {"sd", 48'h0}};
      4'd10:   w = '{4'd3, {"ble", 40'h0}};
      4'd11:   w = '{4'd5, {"radio", 24'h0}};
      4'd12:   w = '{4'd3, {"utc", 40'h0}};
      4'd13:   w = '{4'd3, {"i2c", 40'h0}};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic word_t tok2_word(logic [4:0] i);
    word_t w;
    w = '0;
    case (i)
      5'd0:    w = '{4'd4, {"adxl", 32'h0}};
      5'd1:    w = '{4'd3, {"lsm", 40'h0}};
      5'd2:    w = '{4'd3, {"mmc", 40'h0}};
      5'd3:    w = '{4'd4, {"baro", 32'h0}};
      5'd4:    w = '{4'd3, {"bno", 40'h0}};
      5'd5:    w = '{4'd4, {"gnss", 32'h0}};
      5'd6:    w = '{4'd3, {"ble", 40'h0}};
      5'd7:    w = '{4'd5, {"radio", 24'h0}};
      5'd8:    w = '{4'd5, {"mount", 24'h0}};
      5'd9:    w = '{4'd4, {"read", 32'h0}};
      5'd10:   w = '{4'd4, {"test", 32'h0}};
      5'd11:   w = '{4'd7, {"unmount", 8'h0}};
      5'd12:   w = '{4'd7, {"profile", 8'h0}};
      5'd13:   w = '{4'd4, {"data", 32'h0}};
      5'd14:   w = '{4'd7, {"command", 8'h0}};
      5'd15:   w = '{4'd4, {"ping", 32'h0}};
      5'd16:   w = '{4'd2, {"id", 48'h0}};
      default: w = '0;
    endcase
    return w;
  endfunction

  // Character at position p of a left-justified word, zero past its end.
  function automatic logic [7:0] word_char(logic [63:0] t, logic [2:0] p);
    logic [63:0] s;
    s = t << {p, 3'b000};
    return s[63:56];
  endfunction

endpackage

// ----- sv/command_line_framer_parser.sv -----
// Top level of the command line framer and parser.
//
//  channel | direction | beat accepted when     | payload
//  --------+-----------+------------------------+----------------------------
//  input   | in        | push_i && !full_o      | in_item_i  (clfp_in_t)
//  result  | out       | pop_i && !empty_o      | res_item_o (clfp_out_t)
//
// An input beat is taken whenever the event queue has room; the
// front end updates the fill count and discard flag in that same cycle.
// Each stored byte, line end and framing reset becomes one event, and the
// parser retires one event per cycle unless a line end waits for the result
// register, matching tokens incrementally. A line feed is queued as an event
// first, and its result is latched when that event leaves the queue.
// Reset is asynchronous and active low; it empties the event queue and the
// result register and clears framing state.
// If the result register is still held, a line end waits in the queue, and
// input beats stall only once the event queue is full.
`timescale 1ns / 1ps
module command_line_framer_parser #(
  parameter int unsigned LINE_CAPACITY = clfp_pkg::LineCapacityDef,
  parameter int unsigned EV_DEPTH      = clfp_pkg::EvDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  clfp_pkg::clfp_in_t  in_item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output clfp_pkg::clfp_out_t res_item_o
);
  import clfp_pkg::*;

  logic ev_push, ev_valid, ev_pop, take;
  ev_t  ev_in, ev_out;

  // A beat is taken only when its event, if any, is sure to fit.
  assign take = push_i && !full_o;

  clfp_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .item_i    (in_item_i),
    .ev_push_o (ev_push),
    .ev_o      (ev_in)
  );

  clfp_fifo #(
    .DEPTH(EV_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .full_o  (full_o),
    .pop_i   (ev_pop),
    .valid_o (ev_valid),
    .data_o  (ev_out)
  );

  clfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (ev_valid),
    .ev_i       (ev_out),
    .ev_pop_o   (ev_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .res_o      (res_item_o)
  );

endmodule

// ----- sv/clfp_front.sv -----
// Front end: line framing, discard tracking and byte classification into events.
`timescale 1ns / 1ps
module clfp_front #(
  parameter int unsigned LINE_CAPACITY = clfp_pkg::LineCapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  clfp_pkg::clfp_in_t item_i,
  output logic               ev_push_o,
  output clfp_pkg::ev_t      ev_o
);
  import clfp_pkg::*;

  localparam int unsigned FW = $clog2(LINE_CAPACITY);

  logic [FW-1:0] fill_q, fill_d;
  logic          discard_q, discard_d;
  logic [FW:0]   fill_next;
  logic          bad_byte;

  assign fill_next = {1'b0, fill_q} + (FW+1)'(1);
  assign bad_byte  = (item_i.data_byte != ChCr) &&
                     ((item_i.data_byte < ChSpace) || (item_i.data_byte > ChTilde));

  always_comb begin
    fill_d    = fill_q;
    discard_d = discard_q;
    ev_push_o = 1'b0;
    ev_o.kind = EV_BYTE;
    ev_o.data = item_i.data_byte;
    if (take_i) begin
      if (item_i.action) begin
        fill_d    = '0;
        discard_d = item_i.discard_after_reset;
        ev_push_o = 1'b1;
        ev_o.kind = EV_CLEAR;
      end else if (item_i.data_byte != ChLf) begin
        if (!discard_q) begin
          if ((fill_next >= (FW+1)'(LINE_CAPACITY)) || bad_byte) begin
            discard_d = 1'b1;
          end else begin
            fill_d    = fill_next[FW-1:0];
            ev_push_o = 1'b1;
          end
        end
      end else begin
        ev_push_o = 1'b1;
        ev_o.kind = discard_q ? EV_END_REJ : EV_END;
        fill_d    = '0;
        discard_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      discard_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      discard_q <= discard_d;
    end
  end

endmodule

// ----- sv/clfp_fifo.sv -----
// Short event queue between the front end and the parser.
`timescale 1ns / 1ps
module clfp_fifo #(
  parameter int unsigned DEPTH = clfp_pkg::EvDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  clfp_pkg::ev_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output clfp_pkg::ev_t data_o
);
  import clfp_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  ev_t         mem_q [DEPTH];
  logic [AW:0] wptr_q, rptr_q;

  assign full_o  = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
  assign valid_o = (wptr_q != rptr_q);
  assign data_o  = mem_q[rptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q[AW-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + (AW+1)'(1);
      end
      if (pop_i && valid_o) begin
        rptr_q <= rptr_q + (AW+1)'(1);
      end
    end
  end

endmodule

// ----- sv/clfp_back.sv -----
// Parser back end: incremental tokenizing and word matching, command check per line.
`timescale 1ns / 1ps
module clfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ev_valid_i,
  input  clfp_pkg::ev_t       ev_i,
  output logic                ev_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output clfp_pkg::clfp_out_t res_o
);
  import clfp_pkg::*;

  logic        seen_any_q, seen_any_d, seen_real_q, seen_real_d;
  logic        pend_cr_q, pend_cr_d, bad_q, bad_d, in_tok_q, in_tok_d;
  logic [3:0]  tok_cnt_q, tok_cnt_d, cpos_q, cpos_d;
  logic [31:0] id_q, id_d;
  logic        id_bad_q, id_bad_d;
  logic [N1-1:0] cand1_q, cand1_d, m1;
  logic [N2-1:0] cand2_q, cand2_d, m2;
  logic [3:0]  len1_q, len1_d, len2_q, len2_d;
  logic [11:0] num_q [MaxTokens];
  logic [11:0] num_d;
  logic [MaxTokens-1:0] nbad_q, nbad_d;
  logic        res_valid_q;
  clfp_out_t   res_q, res_new;

  logic        is_end, out_free, starting, is_digit, nb_base;
  logic [2:0]  idx;
  logic [3:0]  pos;
  logic [7:0]  c, digit;
  logic [35:0] id_mul;
  logic [15:0] num_mul;
  logic [11:0] num_base;
  logic [31:0] id_base;
  logic        ok;

  assign c        = ev_i.data;
  assign is_end   = (ev_i.kind == EV_END) || (ev_i.kind == EV_END_REJ);
  assign out_free = !res_valid_q || pop_i;
  assign ev_pop_o = ev_valid_i && (!is_end || out_free);
  assign starting = !in_tok_q;
  assign idx      = starting ? tok_cnt_q[2:0] : 3'(tok_cnt_q - 4'd1);
  assign pos      = starting ? 4'd0 : cpos_q;
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign digit    = c - ChZero;
  assign id_base  = starting ? 32'd0 : id_q;
  assign id_mul   = ({4'd0, id_base} << 3) + ({4'd0, id_base} << 1) + 36'(digit[3:0]);
  assign num_base = starting ? 12'd0 : num_q[idx];
  assign nb_base  = starting ? 1'b0 : nbad_q[idx];
  assign num_mul  = ({4'd0, num_base} << 3) + ({4'd0, num_base} << 1) + 16'(digit[3:0]);

  // Per-byte token tracking; clear and line-end events reset the token count and flags.
  always_comb begin
    seen_any_d  = seen_any_q;
    seen_real_d = seen_real_q;
    pend_cr_d   = pend_cr_q;
    bad_d       = bad_q;
    in_tok_d    = in_tok_q;
    tok_cnt_d   = tok_cnt_q;
    cpos_d      = cpos_q;
    id_d        = id_q;
    id_bad_d    = id_bad_q;
    cand1_d     = cand1_q;
    cand2_d     = cand2_q;
    len1_d      = len1_q;
    len2_d      = len2_q;
    num_d       = num_base;
    nbad_d      = nbad_q;
    if (ev_pop_o) begin
      if (ev_i.kind != EV_BYTE) begin
        seen_any_d  = 1'b0;
        seen_real_d = 1'b0;
        pend_cr_d   = 1'b0;
        bad_d       = 1'b0;
        in_tok_d    = 1'b0;
        tok_cnt_d   = '0;
      end else begin
        seen_any_d = 1'b1;
        // A carriage return is only harmless as the last byte of the line.
        if (pend_cr_q) begin
          bad_d = 1'b1;
        end
        if (c == ChCr) begin
          pend_cr_d = 1'b1;
        end else begin
          seen_real_d = 1'b1;
          if (c == ChSpace) begin
            in_tok_d = 1'b0;
          end else begin
            in_tok_d = 1'b1;
            if (starting) begin
              if (tok_cnt_q == 4'(MaxTokens)) begin
                bad_d = 1'b1;
              end else begin
                tok_cnt_d = tok_cnt_q + 4'd1;
              end
            end
            if (!(starting && (tok_cnt_q == 4'(MaxTokens)))) begin
              cpos_d = (pos == 4'd8) ? pos : pos + 4'd1;
              if (idx == 3'd0) begin
                id_d     = id_mul[31:0];
                id_bad_d = (!starting && id_bad_q) || !is_digit || (|id_mul[35:32]);
              end
              if (idx == 3'd1) begin
                len1_d = cpos_d;
                for (int i = 0; i < N1; i++) begin
                  cand1_d[i] = (starting || cand1_q[i]) && !pos[3] &&
                               (word_char(tok1_word(4'(i)).text, pos[2:0]) == c);
                end
              end
              if (idx == 3'd2) begin
                len2_d = cpos_d;
                for (int i = 0; i < N2; i++) begin
                  cand2_d[i] = (starting || cand2_q[i]) && !pos[3] &&
                               (word_char(tok2_word(5'(i)).text, pos[2:0]) == c);
                end
              end
              num_d       = num_mul[11:0];
              nbad_d[idx] = nb_base || !is_digit || (|num_mul[15:12]);
            end
          end
        end
      end
    end
  end

  // Command check at the end of a line.
  always_comb begin
    for (int i = 0; i < N1; i++) begin
      m1[i] = cand1_q[i] && (len1_q == tok1_word(4'(i)).len);
    end
    for (int i = 0; i < N2; i++) begin
      m2[i] = cand2_q[i] && (len2_q == tok2_word(5'(i)).len);
    end
    ok      = 1'b0;
    res_new = '0;
    if (!bad_q && (tok_cnt_q >= 4'd2) && !id_bad_q && (id_q != 32'd0)) begin
      if (tok_cnt_q == 4'd2) begin
        for (int k = 0; k < 6; k++) begin
          if (m1[k]) begin
            ok = 1'b1;
            res_new.operation = OP_HELLO + 5'(k);
          end
        end
      end else if (tok_cnt_q == 4'd3) begin
        if (m1[W1_PROBE]) begin
          for (int k = 0; k < 8; k++) begin
            if (m2[k]) begin
              ok = 1'b1;
              res_new.operation = OP_PROBE;
              res_new.arg_first = 12'(k);
            end
          end
        end else if (m1[W1_LED] || m1[W1_GPIO]) begin
          if (!nbad_q[2] && (num_q[2] <= GPIO_HIGH) &&
              (!m1[W1_LED] || (num_q[2] == 12'd0))) begin
            ok = 1'b1;
            res_new.operation = m1[W1_LED] ? OP_LED : OP_GPIO;
            res_new.arg_first = num_q[2];
          end
        end else begin
          for (int k = 0; k < 4; k++) begin
            if (m1[W1_SD] && m2[W2_MOUNT+k]) begin
              ok = 1'b1;
              res_new.operation = OP_SD_MOUNT + 5'(k);
            end
            if (m1[W1_BLE] && m2[W2_PROFILE+k]) begin
              ok = 1'b1;
              res_new.operation = OP_BLE_PROF + 5'(k);
            end
          end
          if (m1[W1_RADIO] && m2[W2_ID]) begin
            ok = 1'b1;
            res_new.operation = OP_RADIO_ID;
          end
          if (m1[W1_RADIO] && m2[W2_PING]) begin
            ok = 1'b1;
            res_new.operation = OP_RADIO_PG;
          end
        end
      end else if (tok_cnt_q == 4'd8) begin
        if (m1[W1_UTC]) begin
          ok = 1'b1;
          for (int k = 0; k < 6; k++) begin
            if (nbad_q[k+2] || (num_q[k+2] < UTC_LOW[k]) || (num_q[k+2] > UTC_HIGH[k])) begin
              ok = 1'b0;
            end
          end
          res_new.operation  = OP_UTC;
          res_new.arg_first  = num_q[2];
          res_new.arg_second = num_q[3][7:0];
          res_new.arg_third  = num_q[4][4:0];
          res_new.arg_fourth = num_q[5][4:0];
          res_new.arg_fifth  = num_q[6][5:0];
          res_new.arg_sixth  = num_q[7][5:0];
        end
      end else if (tok_cnt_q == 4'd4) begin
        if (m1[W1_I2C] && !nbad_q[2] && !nbad_q[3] && (num_q[2] >= I2C_LOW) &&
            (num_q[2] <= I2C_HIGH) && (num_q[3] <= REG_HIGH)) begin
          ok = 1'b1;
          res_new.operation  = OP_I2C;
          res_new.arg_first  = num_q[2];
          res_new.arg_second = num_q[3][7:0];
        end
      end
    end
    if (ok && seen_real_q && (ev_i.kind == EV_END)) begin
      res_new.status     = ST_VALID;
      res_new.command_id = id_q;
    end else begin
      res_new        = '0;
      res_new.status = (!seen_any_q && (ev_i.kind == EV_END)) ? ST_EMPTY : ST_REJECT;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    cand1_q <= cand1_d;
    cand2_q <= cand2_d;
    len1_q  <= len1_d;
    len2_q  <= len2_d;
    if (ev_pop_o && (ev_i.kind == EV_BYTE)) begin
      num_q[idx] <= num_d;
    end
    if (ev_pop_o && is_end) begin
      res_q <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_any_q  <= 1'b0;
      seen_real_q <= 1'b0;
      pend_cr_q   <= 1'b0;
      bad_q       <= 1'b0;
      in_tok_q    <= 1'b0;
      tok_cnt_q   <= '0;
      cpos_q      <= '0;
      id_bad_q    <= 1'b0;
      nbad_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      seen_any_q  <= seen_any_d;
      seen_real_q <= seen_real_d;
      pend_cr_q   <= pend_cr_d;
      bad_q       <= bad_d;
      in_tok_q    <= in_tok_d;
      tok_cnt_q   <= tok_cnt_d;
      cpos_q      <= cpos_d;
      id_bad_q    <= id_bad_d;
      nbad_q      <= nbad_d;
      if (ev_pop_o && is_end) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign empty_o = !res_valid_q;
  assign res_o   = res_q;

endmodule

// ----- sim/command_line_framer_parser_tb.sv -----
// Self-checking testbench of the command line framer and parser.
`timescale 1ns / 1ps
module command_line_framer_parser_tb;
  import clfp_pkg::*;

  localparam int unsigned LineCap   = 64;
  localparam int unsigned StallLimit = 20000;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  clfp_in_t in_item;
  logic empty;
  logic pop;
  clfp_out_t res_item;

  command_line_framer_parser dut (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_o(full),
    .in_item_i(in_item), .empty_o(empty), .pop_i(pop), .res_item_o(res_item)
  );

  // Predictor state: a mirror of the framing state of the block.
  logic [7:0] line_buf [LineCap];
  int unsigned line_fill;
  bit line_discard;
  clfp_out_t pending_lines [$];

  int unsigned mismatch_count;
  bit timed_out;
  bit send_idle_on;
  bit recv_idle_on;
  bit recv_hold;
  int unsigned idle_cycles;

  // Token table of the line being parsed.
  int unsigned tok_at [8];
  int unsigned tok_len [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit tok_is(int unsigned t, string w);
    if (tok_len[t] != w.len()) return 1'b0;
    for (int k = 0; k < w.len(); k++) begin
      if (line_buf[tok_at[t] + k] != w[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decimal token value; returns 0 when not all digits or above 32 bits.
  function automatic bit tok_value(int unsigned t, output logic [31:0] v);
    logic [63:0] n;
    logic [7:0] c;
    n = '0;
    v = '0;
    if (tok_len[t] == 0) return 1'b0;
    for (int k = 0; k < tok_len[t]; k++) begin
      c = line_buf[tok_at[t] + k];
      if (c < "0" || c > "9") return 1'b0;
      n = n * 10 + (c - "0");
      if (n > 64'hFFFF_FFFF) return 1'b0;
    end
    v = n[31:0];
    return 1'b1;
  endfunction

  // Parses the first len stored bytes; fills r and returns 1 when valid.
  function automatic bit parse_command(int unsigned len, inout clfp_out_t r);
    string simple [6] = '{"hello", "status", "beep", "stop", "uart", "spi"};
    string devs [8] = '{"adxl", "lsm", "mmc", "baro", "bno", "gnss", "ble", "radio"};
    string verbs [10] = '{"sd", "sd", "sd", "sd", "ble", "ble", "ble", "ble",
                          "radio", "radio"};
    string nouns [10] = '{"mount", "read", "test", "unmount", "profile", "data",
                          "command", "ping", "id", "ping"};
    int unsigned lo [6] = '{2000, 1, 1, 0, 0, 0};
    int unsigned hi [6] = '{2099, 12, 31, 23, 59, 59};
    int unsigned i;
    int unsigned cnt;
    logic [31:0] v [6];
    logic [31:0] id;
    bit is_led;
    i = 0;
    cnt = 0;
    while (i < len) begin
      if (line_buf[i] == ChSpace) begin
        i++;
        continue;
      end
      if (cnt == MaxTokens) return 1'b0;
      tok_at[cnt] = i;
      while (i < len && line_buf[i] != ChSpace) begin
        if (line_buf[i] < 8'h21 || line_buf[i] > ChTilde) return 1'b0;
        i++;
      end
      tok_len[cnt] = i - tok_at[cnt];
      cnt++;
    end
    if (cnt < 2 || !tok_value(0, id) || id == 0) return 1'b0;
    r.command_id = id;
    if (cnt == 2) begin
      for (int k = 0; k < 6; k++) begin
        if (tok_is(1, simple[k])) begin
          r.operation = 5'(k);
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (cnt == 3) begin
      if (tok_is(1, "probe")) begin
        for (int k = 0; k < 8; k++) begin
          if (tok_is(2, devs[k])) begin
            r.operation = OP_PROBE;
            r.arg_first = 12'(k);
            return 1'b1;
          end
        end
        return 1'b0;
      end
      if (tok_is(1, "led") || tok_is(1, "gpio")) begin
        is_led = tok_is(1, "led");
        if (!tok_value(2, v[0]) || v[0] > 7) return 1'b0;
        if (is_led && v[0] != 0) return 1'b0;
        r.operation = is_led ? OP_LED : OP_GPIO;
        r.arg_first = v[0][11:0];
        return 1'b1;
      end
      for (int k = 0; k < 10; k++) begin
        if (tok_is(1, verbs[k]) && tok_is(2, nouns[k])) begin
          r.operation = OP_SD_MOUNT + 5'(k);
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (cnt == 8 && tok_is(1, "utc")) begin
      for (int k = 0; k < 6; k++) begin
        if (!tok_value(k + 2, v[k]) || v[k] < lo[k] || v[k] > hi[k]) return 1'b0;
      end
      r.operation  = OP_UTC;
      r.arg_first  = v[0][11:0];
      r.arg_second = v[1][7:0];
      r.arg_third  = v[2][4:0];
      r.arg_fourth = v[3][4:0];
      r.arg_fifth  = v[4][5:0];
      r.arg_sixth  = v[5][5:0];
      return 1'b1;
    end
    if (cnt == 4 && tok_is(1, "i2c")) begin
      if (!tok_value(2, v[0]) || !tok_value(3, v[1])) return 1'b0;
      if (v[0] < 8 || v[0] > 119 || v[1] > 255) return 1'b0;
      r.operation  = OP_I2C;
      r.arg_first  = v[0][11:0];
      r.arg_second = v[1][7:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predictor by one accepted input beat.
  task automatic predict_beat(clfp_in_t it);
    clfp_out_t r;
    int unsigned len;
    if (it.action) begin
      line_fill = 0;
      line_discard = it.discard_after_reset;
      return;
    end
    if (it.data_byte != ChLf) begin
      if (line_discard) return;
      if (line_fill + 1 >= LineCap ||
          (it.data_byte != ChCr && (it.data_byte < ChSpace || it.data_byte > ChTilde))) begin
        line_discard = 1'b1;
        return;
      end
      line_buf[line_fill] = it.data_byte;
      line_fill++;
      return;
    end
    r = '0;
    r.status = ST_EMPTY;
    if (line_discard) begin
      r.status = ST_REJECT;
    end else if (line_fill != 0) begin
      len = line_fill;
      if (line_buf[len - 1] == ChCr) len--;
      if (len != 0 && parse_command(len, r)) r.status = ST_VALID;
      else r.status = ST_REJECT;
    end
    // Only a valid command carries an operation, an id and arguments.
    if (r.status != ST_VALID) r = '{status: r.status, default: '0};
    line_fill = 0;
    line_discard = 1'b0;
    pending_lines.push_back(r);
  endtask

  // Offers one beat, holding it until accepted, then updates the predictor.
  // Push stays high after acceptance; the next beat or a drain takes it down.
  task automatic send_beat(clfp_in_t it);
    while (send_idle_on && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_beat(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat('{action: 1'b0, data_byte: b, discard_after_reset: 1'($urandom)});
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic send_line(string s);
    send_text(s);
    send_byte(ChLf);
  endtask

  task automatic send_reset(bit disc);
    send_beat('{action: 1'b1, data_byte: 8'($urandom), discard_after_reset: disc});
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // Result checker: every popped beat is compared with the oldest prediction.
  always @(posedge clk) begin
    clfp_out_t want;
    if (rst_n && pop && !empty) begin
      if (pending_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %p", res_item);
      end else begin
        want = pending_lines.pop_front();
        if (res_item !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p, got %p", want, res_item);
        end
      end
    end
  end

  // Receiver: random pops, with a hold-off window controlled by recv_hold.
  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= !recv_hold && !(recv_idle_on && $urandom_range(99) < 12);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst_n && ((push && !full) || (pop && !empty) || recv_hold)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end

  // Directed lines: a selection of commands, argument extremes and the framing cases.
  task automatic test_directed();
    send_line("");
    send_line("1 hello");
    send_line("4294967295 status");
    send_line("4294967296 beep");
    send_line("0 stop");
    send_line(" 7  uart spi");
    send_line("2 probe radio");
    send_line("3 led 0");
    send_line("3 gpio 7");
    send_line("5 sd unmount");
    send_line("6 ble command");
    send_line("8 radio id");
    send_line("9 utc 2099 12 31 23 59 59\r");
    send_line("9 utc 2000 1 1 0 0 0");
    send_line("10 i2c 119 255");
    send_line("10 i2c 7 0");
    send_line("\r");
    send_line("1 he\rllo");
    send_text("1 he");
    send_byte(8'hFF);
    send_line("llo");
    send_reset(1'b1);
    send_line("1 hello");
    send_text("1 hel");
    send_reset(1'b0);
    send_line("1 spi");
    for (int k = 0; k < 70; k++) send_byte("a");
    send_byte(ChLf);
    wait_drained();
  endtask

  function automatic string rand_command();
    string words [21] = '{"hello", "status", "beep", "stop", "uart", "spi",
                          "probe gnss", "led 0", "gpio 5", "sd mount", "sd read",
                          "sd test", "sd unmount", "ble profile", "ble data",
                          "ble command", "ble ping", "radio id", "radio ping",
                          "utc", "i2c"};
    string s;
    int unsigned w;
    w = $urandom_range(20);
    s = $sformatf("%0d %s", $urandom_range(3) == 0 ? $urandom : $urandom_range(999),
                  words[w]);
    if (w == 19)
      s = $sformatf("%s %0d %0d %0d %0d %0d %0d", s, $urandom_range(1995, 2105),
                    $urandom_range(13), $urandom_range(32), $urandom_range(24),
                    $urandom_range(60), $urandom_range(60));
    else if (w == 20)
      s = $sformatf("%s %0d %0d", s, $urandom_range(6, 121), $urandom_range(257));
    return s;
  endfunction

  // Random lines: mostly well formed with random content, some corrupted.
  task automatic test_random(int unsigned n_beats);
    string s;
    int unsigned sent;
    int unsigned p;
    sent = 0;
    while (sent < n_beats) begin
      s = rand_command();
      case ($urandom_range(9))
        0: begin
          p = $urandom_range(s.len() - 1);
          s[p] = 8'($urandom);
        end
        1: s = {s, "\r"};
        2: send_reset(1'($urandom));
        default: ;
      endcase
      for (int k = 0; k < s.len(); k++) begin
        if (s[k] == ChLf) send_byte("x");
        else send_byte(s[k]);
      end
      send_byte(ChLf);
      sent += s.len() + 1;
    end
  endtask

  // The receiver stops while the sender keeps going, so the block backs up.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        for (int c = 0; c < 300; c++) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_line("1 hello");
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    line_fill = 0;
    line_discard = 1'b0;
    mismatch_count = 0;
    timed_out = 1'b0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    recv_hold = 1'b0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    test_random(300);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_random(620);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_lines.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
